FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, off during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, consequent checked in the cycle after the antecedent, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/a32icd_pkg.sv
`timescale 1ns / 1ps
// Types and constant pattern table of the A32 instruction class decoder.
// No dependencies.
package a32icd_pkg;

   localparam int ClassCount = 97;
   localparam int IndexWidth = 7;
   localparam int WordWidth  = 32;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [IndexWidth-1:0] index_type;

   typedef struct packed {
      word_type mask;   // 1 = fixed bit
      word_type value;  // fixed bit values
   } pattern_type;

   // Entry i is pattern i in priority order, lowest wins.
   localparam pattern_type PatternTable [ClassCount] = '{
      // data processing, shift by immediate
      '{32'h0FE00010, 32'h00000000}, '{32'h0FE00010, 32'h00200000},
      '{32'h0FE00010, 32'h00400000}, '{32'h0FE00010, 32'h00600000},
      '{32'h0FE00010, 32'h00800000}, '{32'h0FE00010, 32'h00A00000},
      '{32'h0FE00010, 32'h00C00000}, '{32'h0FE00010, 32'h00E00000},
      '{32'h0FF0F010, 32'h01100000}, '{32'h0FF0F010, 32'h01300000},
      '{32'h0FF0F010, 32'h01500000}, '{32'h0FF0F010, 32'h01700000},
      '{32'h0FE00010, 32'h01800000}, '{32'h0FEF0010, 32'h01A00000},
      '{32'h0FE00010, 32'h01C00000}, '{32'h0FEF0010, 32'h01E00000},
      // data processing, shift by register
      '{32'h0FE00090, 32'h00000010}, '{32'h0FE00090, 32'h00200010},
      '{32'h0FE00090, 32'h00400010}, '{32'h0FE00090, 32'h00600010},
      '{32'h0FE00090, 32'h00800010}, '{32'h0FE00090, 32'h00A00010},
      '{32'h0FE00090, 32'h00C00010}, '{32'h0FE00090, 32'h00E00010},
      '{32'h0FF0F090, 32'h01100010}, '{32'h0FF0F090, 32'h01300010},
      '{32'h0FF0F090, 32'h01500010}, '{32'h0FF0F090, 32'h01700010},
      '{32'h0FE00090, 32'h01800010}, '{32'h0FEF0090, 32'h01A00010},
      '{32'h0FE00090, 32'h01C00010}, '{32'h0FEF0090, 32'h01E00010},
      // data processing, immediate; MSR immediate
      '{32'h0FE00000, 32'h02000000}, '{32'h0FE00000, 32'h02200000},
      '{32'h0FE00000, 32'h02400000}, '{32'h0FE00000, 32'h02600000},
      '{32'h0FE00000, 32'h02800000}, '{32'h0FE00000, 32'h02A00000},
      '{32'h0FE00000, 32'h02C00000}, '{32'h0FE00000, 32'h02E00000},
      '{32'h0FF0F000, 32'h03100000}, '{32'h0FF0F000, 32'h03300000},
      '{32'h0FF0F000, 32'h0320F000}, '{32'h0FF0F000, 32'h03500000},
      '{32'h0FF0F000, 32'h03700000}, '{32'h0FF0F000, 32'h0360F000},
      '{32'h0FE00000, 32'h03800000}, '{32'h0FEF0000, 32'h03A00000},
      '{32'h0FE00000, 32'h03C00000}, '{32'h0FEF0000, 32'h03E00000},
      // MRS, SWP, MSR register, BX
      '{32'h0FFF0FFF, 32'h010F0000}, '{32'h0FF00FF0, 32'h01000090},
      '{32'h0FF0FFF0, 32'h0120F000}, '{32'h0FFFFFF0, 32'h012FFF10},
      '{32'h0FFF0FFF, 32'h014F0000}, '{32'h0FF00FF0, 32'h01400090},
      '{32'h0FF0FFF0, 32'h0160F000},
      // multiplies
      '{32'h0FE0F0F0, 32'h00000090}, '{32'h0FE000F0, 32'h00200090},
      '{32'h0FE000F0, 32'h00800090}, '{32'h0FE000F0, 32'h00A00090},
      '{32'h0FE000F0, 32'h00C00090}, '{32'h0FE000F0, 32'h00E00090},
      // halfword and signed transfers
      '{32'h0E1000F0, 32'h000000B0}, '{32'h0E1000F0, 32'h001000B0},
      '{32'h0E1000F0, 32'h001000D0}, '{32'h0E1000F0, 32'h001000F0},
      // single transfer, immediate offset
      '{32'h0E500000, 32'h04000000}, '{32'h0E500000, 32'h04100000},
      '{32'h0E500000, 32'h04400000}, '{32'h0E500000, 32'h04500000},
      '{32'h0F700000, 32'h04200000}, '{32'h0F700000, 32'h04300000},
      '{32'h0F700000, 32'h04600000}, '{32'h0F700000, 32'h04700000},
      // single transfer, register offset
      '{32'h0E500010, 32'h06000000}, '{32'h0E500010, 32'h06100000},
      '{32'h0E500010, 32'h06400000}, '{32'h0E500010, 32'h06500000},
      '{32'h0F700010, 32'h06200000}, '{32'h0F700010, 32'h06300000},
      '{32'h0F700010, 32'h06600000}, '{32'h0F700010, 32'h06700000},
      // block transfers
      '{32'h0E500000, 32'h08000000}, '{32'h0E500000, 32'h08100000},
      '{32'h0E708000, 32'h08400000}, '{32'h0E708000, 32'h08600000},
      '{32'h0E508000, 32'h08408000}, '{32'h0E508000, 32'h08508000},
      // branches
      '{32'h0F000000, 32'h0A000000}, '{32'h0F000000, 32'h0B000000},
      // coprocessor transfers
      '{32'h0E100000, 32'h0C000000}, '{32'h0E100000, 32'h0C100000},
      // CDP, MCR, MRC
      '{32'h0F000010, 32'h0E000000}, '{32'h0F100010, 32'h0E000010},
      '{32'h0F100010, 32'h0E100010},
      // SWI
      '{32'h0F000000, 32'h0F000000}
   };

endpackage

FILE: src/a32_instruction_class_decoder.sv
`timescale 1ns / 1ps
// Channel  Ports                                     Direction
// req      req_valid, req_ready, req_instr_word      in
// rsp      rsp_valid, rsp_ready, rsp_class_index,    out
//          rsp_matched
//
// One word per cycle sustained while rsp_ready stays high.
// Stage 1 registers the word, stage 2 registers the 97-way compare and
// priority pick. A full stage holds while a result waits with rsp_ready low;
// an empty stage still loads regardless of rsp_ready.
// Synchronous reset clears the valid bits only; no warm-up period.
// Depends on a32icd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module a32_instruction_class_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  a32icd_pkg::word_type        req_instr_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output a32icd_pkg::index_type       rsp_class_index,
   output logic                        rsp_matched
);
   import a32icd_pkg::*;

   logic                  word_valid_ff, word_valid_in;
   word_type              word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   index_type             index_ff;
   logic                  matched_ff;
   logic                  out_take;
   logic                  word_move;
   logic [ClassCount-1:0] hit;
   index_type             pick;
   logic                  any_hit;

   // stage 2 can load when empty or being drained
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign word_move = word_valid_ff && out_take;
   assign req_ready = !word_valid_ff || out_take;

   always_comb begin
      for (int i = 0; i < ClassCount; i++) begin
         hit[i] = ((word_ff ^ PatternTable[i].value) & PatternTable[i].mask) == '0;
      end
   end

   // lowest matching position wins
   always_comb begin
      pick = '0;
      for (int i = ClassCount - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pick = IndexWidth'(i);
         end
      end
   end

   assign any_hit = |hit;

   always_comb begin
      word_valid_in = word_valid_ff;
      if (req_valid && req_ready) begin
         word_valid_in = 1'b1;
      end else if (word_move) begin
         word_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_take) begin
         rsp_valid_in = word_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_instr_word;
      end
      if (word_move) begin
         index_ff   <= pick;
         matched_ff <= any_hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = index_ff;
   assign rsp_matched     = matched_ff;

   `ASSERT_CLK(a_nomatch_zero, clock, reset,
      !rsp_valid_ff || matched_ff || index_ff == '0, "unmatched word with nonzero index")
   `ASSERT_CLK(a_index_range, clock, reset,
      !rsp_valid_ff || index_ff < IndexWidth'(ClassCount), "class index out of range")
   `ASSERT_CLK(a_full_stall, clock, reset,
      !(word_valid_ff && rsp_valid_ff && !rsp_ready) || !req_ready,
      "input taken while both stages are full and stalled")
   `ASSERT_NEXT(a_advance, clock, reset, word_move, rsp_valid_ff,
      "stage 1 word advanced but no result shown")

endmodule
